// File: rtl/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg: shared types and constants of the LED strip fade block
// Pixel type, cell control group, controller states and register indexes.
// ----------------------------------------------------------------------------
package lsf_pkg;

    localparam int LED_COUNT = 16;
    localparam int CNT_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int IDX_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_BLUE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_PER   = 2'd3;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_FLASH = 1'b1;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    typedef struct packed {
        logic flash;
        logic step;
        logic shift;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_DECIDE,
        ST_EMIT
    } t_state;

endpackage

// File: rtl/lsf_cell.sv
// ----------------------------------------------------------------------------
// lsf_cell: one pixel of the strip
// Holds one RGB pixel; loads a flash colour, steps each channel by one
// towards the base colour, or takes its neighbour's pixel when the strip
// rotates out through the head of the chain.
// ----------------------------------------------------------------------------
module lsf_cell
    import lsf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_pixel     i_flash,
    input  t_pixel     i_base,
    input  t_pixel     i_next,
    output t_pixel     o_pixel,
    output logic       o_changed
);

    t_pixel r_pixel;
    t_pixel n_pixel;
    logic   r_changed;
    logic   n_changed;

    function automatic logic [7:0] step_chan(input logic [7:0] cur, input logic [7:0] tgt);
        logic [7:0] res;
        if (cur < tgt) begin
            res = cur + 8'd1;
        end else if (cur > tgt) begin
            res = cur - 8'd1;
        end else begin
            res = cur;
        end
        return res;
    endfunction

    always_comb begin
        n_pixel   = r_pixel;
        n_changed = r_changed;
        if (i_ctrl.flash) begin
            n_pixel = i_flash;
        end else if (i_ctrl.step) begin
            n_pixel.red   = step_chan(r_pixel.red,   i_base.red);
            n_pixel.green = step_chan(r_pixel.green, i_base.green);
            n_pixel.blue  = step_chan(r_pixel.blue,  i_base.blue);
            // A pixel moves exactly when it differs from the base colour.
            n_changed     = (r_pixel != i_base);
        end else if (i_ctrl.shift) begin
            n_pixel = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel   <= '0;
            r_changed <= 1'b0;
        end else begin
            r_pixel   <= n_pixel;
            r_changed <= n_changed;
        end
    end

    assign o_pixel   = r_pixel;
    assign o_changed = r_changed;

endmodule

// File: rtl/led_strip_fade_to_base.sv
// ----------------------------------------------------------------------------
// led_strip_fade_to_base: RGB strip that fades one step per period to a base
// Chain of pixel cells with a small controller and an output register.
// ----------------------------------------------------------------------------
// A flash request, or a tick that does not start a fade step, is taken while
// the controller is idle. A tick that wraps the divider while a change is
// pending steps every pixel at once in ST_STEP and judges in ST_DECIDE
// whether any moved, and then, if one did, streams all LED_COUNT pixels out
// in ST_EMIT, one pixel a cycle while the consumer does not stall, as the
// pixels rotate out of the head cell of the chain into the output register.
// Base colour writes in the idle state set the pending flag; period writes do not.
// ----------------------------------------------------------------------------
module led_strip_fade_to_base
    import lsf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [23:0]          i_s_tdata,   // flash_red, flash_green, flash_blue
    input  logic                 i_s_tuser,   // func
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [31:0]          o_m_tdata,   // pixel_index, red, green, blue, zero pad
    output logic                 o_m_tlast,   // last
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_state     r_state, n_state;
    logic       r_pending, n_pending;
    logic [15:0] r_div, n_div;
    logic [CNT_W-1:0] r_count, n_count;
    t_pixel     r_base;
    logic [15:0] r_period;

    logic       r_out_valid;
    t_pixel     r_out_pixel;
    logic [IDX_W-1:0] r_out_index;
    logic       r_out_last;

    t_cell_ctrl w_ctrl;
    t_pixel     w_flash;
    t_pixel     w_pix [LED_COUNT];
    logic [LED_COUNT-1:0] w_changed;
    logic       w_accept;
    logic       w_load_out;
    logic       w_cnt_last;
    logic [16:0] w_period;
    logic [16:0] w_next_div;

    assign w_flash.red   = i_s_tdata[7:0];
    assign w_flash.green = i_s_tdata[15:8];
    assign w_flash.blue  = i_s_tdata[23:16];

    genvar g;
    generate
        for (g = 0; g < LED_COUNT; g++) begin : g_cell
            lsf_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_flash   (w_flash),
                .i_base    (r_base),
                .i_next    (w_pix[(g + 1) % LED_COUNT]),
                .o_pixel   (w_pix[g]),
                .o_changed (w_changed[g])
            );
        end
    endgenerate

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_period   = (r_period == 16'd0) ? 17'd1 : {1'b0, r_period};
    assign w_next_div = {1'b0, r_div} + 17'd1;
    assign w_cnt_last = (r_count == CNT_W'(LED_COUNT - 1));

    always_comb begin
        n_state    = r_state;
        n_pending  = r_pending;
        n_div      = r_div;
        n_count    = r_count;
        w_ctrl     = '0;
        w_load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser == FUNC_FLASH) begin
                        w_ctrl.flash = 1'b1;
                        n_pending    = 1'b1;
                    end else if (w_next_div < w_period) begin
                        n_div = w_next_div[15:0];
                    end else begin
                        n_div = 16'd0;
                        if (r_pending) begin
                            n_state = ST_STEP;
                        end
                    end
                end
                if (i_cfg_we && (i_cfg_index != REG_FADE_PER)) begin
                    n_pending = 1'b1;
                end
            end
            ST_STEP: begin
                w_ctrl.step = 1'b1;
                n_state     = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (|w_changed) begin
                    n_count = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_pending = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    w_load_out   = 1'b1;
                    w_ctrl.shift = 1'b1;
                    n_count      = r_count + CNT_W'(1);
                    if (w_cnt_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pending <= 1'b0;
            r_div     <= 16'd0;
            r_count   <= '0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_div     <= n_div;
            r_count   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_period <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BASE_RED:   r_base.red   <= i_cfg_data[7:0];
                REG_BASE_GREEN: r_base.green <= i_cfg_data[7:0];
                REG_BASE_BLUE:  r_base.blue  <= i_cfg_data[7:0];
                REG_FADE_PER:   r_period     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_pixel <= w_pix[0];
            r_out_index <= IDX_W'(r_count);
            r_out_last  <= w_cnt_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_pixel.blue, r_out_pixel.green,
                         r_out_pixel.red, r_out_index};
    assign o_m_tlast  = r_out_last;

    a_emit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> r_pending)
        else $error("strip emitted without a pending change");

    a_step_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP) |=> (r_state == ST_DECIDE))
        else $error("fade step not followed by decision");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[IDX_W-1:0] == IDX_W'(LED_COUNT - 1)))
        else $error("last marker on a pixel other than the final one");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE && (|w_changed)) |=> (r_count == '0))
        else $error("frame does not start at pixel zero");

endmodule
